/* rtl/core/rhbi_pkg.sv */
// Shared constants and control types for the rolling hash bucket index block.
`default_nettype none

package rhbi_pkg;

  localparam int HashW  = 30;
  localparam int CountW = 16;
  localparam int ByteW  = 8;
  localparam int CntW   = 5;

  // Modulus and the Barrett constant floor(2^60 / modulus).
  localparam logic [HashW-1:0] HashMod     = 30'd1000000009;
  localparam logic [31:0]      HashModX2   = 32'd2000000018;
  localparam logic [63:0]      BarrettNum  = 64'd1 << 60;
  localparam logic [30:0]      BarrettM    = 31'(BarrettNum / 64'(HashMod));

  localparam logic [ByteW-1:0]  CharOffset   = 8'd96;
  localparam logic [HashW-1:0]  ResetBase    = 30'd97;
  localparam logic [CountW-1:0] ResetBuckets = 16'd1024;

  // Pipeline depth of the modular multiplier and length of the remainder loop.
  localparam int MulLatency = 4;
  localparam int DivSteps   = 30;

  typedef struct packed {
    logic            accept;
    logic            update;
    logic            div_step;
    logic [CntW-1:0] div_bit;
    logic            load_out;
  } rhbi_cmd_t;

  typedef struct packed {
    logic last;
  } rhbi_status_t;

endpackage

`default_nettype wire

/* rtl/core/rhbi_mulmod.sv */
// Four-stage Barrett modular multiplier, a * b mod 1000000009.
`default_nettype none

module rhbi_mulmod (
  input  wire logic                       clk,
  input  wire logic [rhbi_pkg::HashW-1:0] a,
  input  wire logic [rhbi_pkg::HashW-1:0] b,
  output logic      [rhbi_pkg::HashW-1:0] r
);

  localparam int HashW = rhbi_pkg::HashW;

  logic [2*HashW-1:0] prod;
  logic [61:0]        quot_wide;
  logic [31:0]        prod_lo_s2;
  logic [31:0]        prod_lo_s3;
  logic [31:0]        qm_lo;
  logic [31:0]        diff;

  // The estimated quotient is at most two below the true one, so the
  // difference stays below three times the modulus.
  assign diff = prod_lo_s3 - qm_lo;

  always_ff @(posedge clk) begin
    prod       <= 60'(a) * 60'(b);
    quot_wide  <= 62'(prod[59:29]) * 62'(rhbi_pkg::BarrettM);
    prod_lo_s2 <= prod[31:0];
    qm_lo      <= 32'(32'(quot_wide[61:31]) * 32'(rhbi_pkg::HashMod));
    prod_lo_s3 <= prod_lo_s2;
    if (diff >= rhbi_pkg::HashModX2) begin
      r <= HashW'(diff - rhbi_pkg::HashModX2);
    end else if (diff >= 32'(rhbi_pkg::HashMod)) begin
      r <= HashW'(diff - 32'(rhbi_pkg::HashMod));
    end else begin
      r <= diff[HashW-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rhbi_datapath.sv */
// Datapath: running hash and power, two multipliers, remainder unit, result register.
`default_nettype none

module rhbi_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rhbi_pkg::rhbi_cmd_t         cmd,
  output rhbi_pkg::rhbi_status_t           status,
  input  wire logic [rhbi_pkg::ByteW-1:0]  key_byte,
  input  wire logic                        key_end,
  input  wire logic [rhbi_pkg::HashW-1:0]  hash_base,
  input  wire logic [rhbi_pkg::CountW-1:0] bucket_count,
  output logic      [rhbi_pkg::HashW-1:0]  full_hash,
  output logic      [rhbi_pkg::CountW-1:0] bucket_index
);

  localparam int HashW  = rhbi_pkg::HashW;
  localparam int CountW = rhbi_pkg::CountW;
  localparam int ByteW  = rhbi_pkg::ByteW;

  logic [HashW-1:0]  running_hash;
  logic [HashW-1:0]  running_power;
  logic [HashW-1:0]  term;
  logic [HashW-1:0]  term_next;
  logic              last;
  logic [HashW-1:0]  prod_term;
  logic [HashW-1:0]  prod_power;
  logic [HashW:0]    hash_sum;
  logic [HashW-1:0]  hash_new;
  logic [HashW-1:0]  div_hash;
  logic [CountW-1:0] rem;
  logic [CountW:0]   rem_shift;
  logic [CountW-1:0] rem_next;

  assign status.last = last;

  // A byte below the offset gives a negative term, kept as its residue.
  always_comb begin
    if (key_byte >= rhbi_pkg::CharOffset) begin
      term_next = {{(HashW-ByteW){1'b0}}, key_byte - rhbi_pkg::CharOffset};
    end else begin
      term_next = rhbi_pkg::HashMod -
                  {{(HashW-ByteW){1'b0}}, rhbi_pkg::CharOffset - key_byte};
    end
  end

  rhbi_mulmod u_mul_term (
    .clk (clk),
    .a   (term),
    .b   (running_power),
    .r   (prod_term)
  );

  rhbi_mulmod u_mul_power (
    .clk (clk),
    .a   (running_power),
    .b   (hash_base),
    .r   (prod_power)
  );

  always_comb begin
    hash_sum = {1'b0, running_hash} + {1'b0, prod_term};
    if (hash_sum >= {1'b0, rhbi_pkg::HashMod}) begin
      hash_new = HashW'(hash_sum - {1'b0, rhbi_pkg::HashMod});
    end else begin
      hash_new = hash_sum[HashW-1:0];
    end
  end

  // One quotient bit per step; the remainder stays below a nonzero divisor.
  always_comb begin
    rem_shift = {rem, div_hash[cmd.div_bit]};
    if (rem_shift >= {1'b0, bucket_count}) begin
      rem_next = CountW'(rem_shift - {1'b0, bucket_count});
    end else begin
      rem_next = rem_shift[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash  <= '0;
      running_power <= HashW'(1);
      last          <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (last) begin
          running_hash  <= '0;
          running_power <= HashW'(1);
        end else begin
          running_hash  <= hash_new;
          running_power <= prod_power;
        end
      end
      if (cmd.accept) begin
        last <= key_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      term <= term_next;
    end
    if (cmd.update && last) begin
      div_hash <= hash_new;
      rem      <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end
    if (cmd.load_out) begin
      full_hash    <= div_hash;
      bucket_index <= (bucket_count == '0) ? '0 : rem;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rhbi_ctrl.sv */
// Controller: sequences multiply wait, state commit, remainder steps and result load.
`default_nettype none

module rhbi_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   key_valid,
  output logic                        key_ready,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  input  wire rhbi_pkg::rhbi_status_t status,
  output rhbi_pkg::rhbi_cmd_t         cmd
);

  localparam int CntW = rhbi_pkg::CntW;

  typedef enum logic [2:0] {
    IDLE,
    MUL,
    UPD,
    DIV,
    FIN
  } state_t;

  state_t          state;
  logic [CntW-1:0] cnt;
  logic            accept;
  logic            out_free;

  assign key_ready = (state == IDLE) || ((state == UPD) && !status.last);
  assign accept    = key_valid && key_ready;
  assign out_free  = !result_valid || result_ready;

  always_comb begin
    cmd.accept   = accept;
    cmd.update   = (state == UPD);
    cmd.div_step = (state == DIV);
    cmd.div_bit  = cnt;
    cmd.load_out = (state == FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !cmd.load_out) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= MUL;
            cnt   <= '0;
          end
        end
        MUL: begin
          if (cnt == CntW'(rhbi_pkg::MulLatency - 1)) begin
            state <= UPD;
          end else begin
            cnt <= cnt + CntW'(1);
          end
        end
        UPD: begin
          if (status.last) begin
            state <= DIV;
            cnt   <= CntW'(rhbi_pkg::DivSteps - 1);
          end else if (accept) begin
            state <= MUL;
            cnt   <= '0;
          end else begin
            state <= IDLE;
          end
        end
        DIV: begin
          if (cnt == '0) begin
            state <= FIN;
          end else begin
            cnt <= cnt - CntW'(1);
          end
        end
        FIN: begin
          if (out_free) begin
            result_valid <= 1'b1;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rolling_hash_bucket_index.sv */
// Top level of the polynomial rolling hash with bucket index, modulo 1000000009.
//
//   Channel  Signals                                    Direction  Moves
//   key      key_valid/key_ready, key_byte, key_end      in         one key byte per transfer
//   result   result_valid/result_ready, full_hash, ...   out        one result per finished key
//   config   psel/penable/pwrite/paddr/pwdata/prdata     in/out     hash_base, bucket_count
//
// A key byte that does not end its key goes through the transfer, the wait in the pipelined
// Barrett multipliers, and a commit cycle in which the next byte can transfer.
// A final byte then also runs the one-bit-per-cycle remainder unit and loads the result
// register, once it is free, before the controller returns to idle for the next transfer.
// Reset returns hash_base to 97, bucket_count to 1024, the running hash to 0 and power to 1.
// A result waits in its register while new key bytes keep flowing; only a second
// finished key holds in the controller until the first result transfer completes.
`default_nettype none

module rolling_hash_bucket_index (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // Key byte channel.
  input  wire logic                        key_valid,
  output logic                             key_ready,
  input  wire logic [rhbi_pkg::ByteW-1:0]  key_byte,
  input  wire logic                        key_end,
  // Result channel.
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic      [rhbi_pkg::HashW-1:0]  full_hash,
  output logic      [rhbi_pkg::CountW-1:0] bucket_index
);

  localparam int HashW  = rhbi_pkg::HashW;
  localparam int CountW = rhbi_pkg::CountW;

  // Register select is address bit 2: hash_base at 0, bucket_count at 4.
  localparam logic RegHashBase    = 1'b0;
  localparam logic RegBucketCount = 1'b1;

  logic [HashW-1:0]       hash_base;
  logic [CountW-1:0]      bucket_count;
  rhbi_pkg::rhbi_cmd_t    cmd;
  rhbi_pkg::rhbi_status_t status;

  assign pready = 1'b1;

  // Configuration registers. Writes land on the access phase of the transfer;
  // the low address bits, paddr[1:0], are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_base    <= rhbi_pkg::ResetBase;
      bucket_count <= rhbi_pkg::ResetBuckets;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        RegHashBase:    hash_base    <= pwdata[HashW-1:0];
        RegBucketCount: bucket_count <= pwdata[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegHashBase:    prdata = {{(32-HashW){1'b0}}, hash_base};
      RegBucketCount: prdata = {{(32-CountW){1'b0}}, bucket_count};
      default:        prdata = '0;
    endcase
  end

  // The controller sequences each byte; the datapath holds the running values and the result.
  rhbi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .key_valid    (key_valid),
    .key_ready    (key_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  rhbi_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .key_byte     (key_byte),
    .key_end      (key_end),
    .hash_base    (hash_base),
    .bucket_count (bucket_count),
    .full_hash    (full_hash),
    .bucket_index (bucket_index)
  );

`ifndef ASSERT_OFF
  // A delivered hash is always a canonical residue.
  a_hash_canonical: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (full_hash < rhbi_pkg::HashMod))
    else $error("full_hash is not reduced below the modulus");

  // The result register is never reloaded while it holds an untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result_valid || result_ready))
    else $error("result register overwritten before its transfer");

  // No key byte is taken while the remainder unit is stepping.
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    (key_valid && key_ready) |-> !cmd.div_step)
    else $error("key byte accepted during bucket remainder steps");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the rolling hash bucket index block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HashW  = rhbi_pkg::HashW;
  localparam int CountW = rhbi_pkg::CountW;
  localparam int ByteW  = rhbi_pkg::ByteW;

  // Register map: one word per register, byte addressed.
  localparam logic [2:0] AddrHashBase    = 3'd0;
  localparam logic [2:0] AddrBucketCount = 3'd4;

  // Arithmetic constants of the hash, kept independent of the RTL package.
  localparam logic [63:0] HashModulus   = 64'd1000000009;
  localparam logic [31:0] KeyCharOffset = 32'd96;

  // A final byte runs the whole remainder loop; leave margin before touching registers.
  localparam int SettleCycles   = 60;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int HoldOffCycles  = 400;
  // Cycles without any transfer before the run is declared hung.
  localparam int WatchdogLimit  = 3000;

  typedef struct packed {
    logic [HashW-1:0]  full_hash;
    logic [CountW-1:0] bucket_index;
  } bucket_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [2:0]        paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic              key_valid = 1'b0;
  logic              key_ready;
  logic [ByteW-1:0]  key_byte  = '0;
  logic              key_end   = 1'b0;

  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [HashW-1:0]  full_hash;
  logic [CountW-1:0] bucket_index;

  // Predictor state: the configuration as last written and the running hash of
  // the key that is in progress.
  logic [HashW-1:0]  cfg_base    = 30'd97;
  logic [CountW-1:0] cfg_buckets = 16'd1024;
  logic [HashW-1:0]  pred_hash   = '0;
  logic [HashW-1:0]  pred_power  = 30'd1;

  // Results that finished keys are owed, oldest first.
  bucket_result_t pending_results[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  bit receiver_hold_request = 1'b0;

  always #10 clk = ~clk;

  rolling_hash_bucket_index u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .key_valid    (key_valid),
    .key_ready    (key_ready),
    .key_byte     (key_byte),
    .key_end      (key_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .full_hash    (full_hash),
    .bucket_index (bucket_index)
  );

  // Product of two residues, reduced modulo the hash modulus. Operands may be
  // any 30-bit value; the 64-bit product cannot overflow.
  function automatic logic [HashW-1:0] mul_mod(input logic [HashW-1:0] a,
                                               input logic [HashW-1:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b);
    return HashW'(prod % HashModulus);
  endfunction

  // Advances the predicted hash by one accepted key byte. When the byte ends
  // its key, the owed result is queued and the running state restarts.
  task automatic advance_hash(input logic [ByteW-1:0] kb, input logic last);
    logic [31:0]    term;
    logic [31:0]    sum;
    bucket_result_t owed;
    // Bytes below the offset give a negative term; use its positive residue.
    if (32'(kb) >= KeyCharOffset) begin
      term = 32'(kb) - KeyCharOffset;
    end else begin
      term = 32'(HashModulus) - (KeyCharOffset - 32'(kb));
    end
    sum = 32'(pred_hash) + 32'(mul_mod(HashW'(term), pred_power));
    if (sum >= 32'(HashModulus)) begin
      sum = sum - 32'(HashModulus);
    end
    pred_hash  = HashW'(sum);
    pred_power = mul_mod(pred_power, cfg_base);
    if (last) begin
      owed.full_hash    = pred_hash;
      // A bucket count of zero yields index zero rather than a division fault.
      owed.bucket_index = (cfg_buckets == '0) ? '0 : CountW'(pred_hash % cfg_buckets);
      pending_results.push_back(owed);
      pred_hash  = '0;
      pred_power = 30'd1;
    end
  endtask

  // Offers one key byte and waits for its transfer. With stay_valid set, the
  // caller promises to offer the next byte at the very next falling edge, so
  // valid is not dropped here.
  task automatic send_key_byte(input logic [ByteW-1:0] kb, input logic last,
                               input logic stay_valid);
    @(negedge clk);
    key_valid <= 1'b1;
    key_byte  <= kb;
    key_end   <= last;
    @(posedge clk);
    while (!key_ready) @(posedge clk);
    advance_hash(kb, last);
    if (!stay_valid) begin
      @(negedge clk);
      key_valid <= 1'b0;
    end
  endtask

  // One APB transaction: a setup cycle, then the access cycle that completes
  // at the rising edge where pready is high. Writes update the predictor's
  // copy of the register at that same edge.
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (wr) begin
      case (addr)
        AddrHashBase:    cfg_base    = wdata[HashW-1:0];
        AddrBucketCount: cfg_buckets = wdata[CountW-1:0];
        default: ;
      endcase
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] rd;
    apb_access(1'b0, addr, '0, rd);
    if (rd !== want) begin
      $error("prdata mismatch at paddr %0d: expected %0d, got %0d", addr, want, rd);
      mismatch_count++;
    end
  endtask

  // Waits until every owed result has been taken, then lets the block finish
  // any byte that owes no result before the caller touches a register.
  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Writes both registers with random junk above the register width, which
  // the block must drop, and reads them back.
  task automatic write_config(input logic [31:0] base, input logic [31:0] buckets);
    logic [31:0] unused;
    wait_idle();
    apb_access(1'b1, AddrHashBase, {2'($urandom), base[HashW-1:0]}, unused);
    apb_access(1'b1, AddrBucketCount, {16'($urandom), buckets[CountW-1:0]}, unused);
    check_register(AddrHashBase, 32'(cfg_base));
    check_register(AddrBucketCount, 32'(cfg_buckets));
  endtask

  // Streams random keys until at least byte_total bytes have gone and the last
  // key is finished. Most bytes are lowercase letters, the alphabet the hash is
  // meant for; the rest span the whole byte range and its edges. The sender
  // works in bursts; at byte pause_after it stops until all results are in.
  task automatic send_random_keys(input int byte_total, input int pause_after);
    int              sent;
    int              key_left;
    int              burst_left;
    int              pick;
    logic [ByteW-1:0] kb;
    logic            stay_valid;
    sent = 0;
    key_left = 0;
    burst_left = 0;
    while (sent < byte_total || key_left != 0) begin
      if (key_left == 0) begin
        key_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        kb = ByteW'($urandom_range(97, 122));
      end else if (pick < 85) begin
        kb = ByteW'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0:       kb = 8'd0;
          1:       kb = 8'd95;
          2:       kb = 8'd96;
          default: kb = 8'd255;
        endcase
      end
      burst_left--;
      key_left--;
      sent++;
      stay_valid = (burst_left != 0) && (sent != pause_after)
                   && (sent < byte_total || key_left != 0);
      send_key_byte(kb, key_left == 0, stay_valid);
      if (sent == pause_after) begin
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (!stay_valid) begin
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
    end
  endtask

  // After reset both registers must read back their documented defaults.
  task automatic test_reset_values();
    check_register(AddrHashBase, 32'd97);
    check_register(AddrBucketCount, 32'd1024);
  endtask

  // Single-byte and short keys at the edges of the byte range under the reset
  // configuration: 'a' (hash 1), zero and 95 (negative terms), 96 (zero term),
  // and 255.
  task automatic test_byte_extremes();
    send_key_byte(8'd97, 1'b1, 1'b0);
    send_key_byte(8'd0, 1'b1, 1'b0);
    send_key_byte(8'd255, 1'b1, 1'b0);
    send_key_byte(8'd96, 1'b0, 1'b1);
    send_key_byte(8'd95, 1'b1, 1'b0);
  endtask

  // Bases of zero and one, the largest residue, the modulus itself and the
  // largest 30-bit value; bucket counts of zero, one and the maximum.
  task automatic test_base_and_count_extremes();
    logic [31:0] bases[6];
    logic [31:0] counts[6];
    bases  = '{32'd0, 32'd1, 32'd2, 32'd1000000008, 32'd1000000009, 32'h3FFF_FFFF};
    counts = '{32'd0, 32'd1, 32'd65535, 32'd3, 32'd1000, 32'hFFFF};
    foreach (bases[i]) begin
      write_config(bases[i], counts[i]);
      send_key_byte(8'd255, 1'b0, 1'b1);
      send_key_byte(8'd0, 1'b0, 1'b1);
      send_key_byte(ByteW'($urandom_range(97, 122)), 1'b1, 1'b0);
    end
  endtask

  // Both registers change between two bytes of one key. The new base applies
  // from the next multiply on, the new count when the key ends, and the
  // running hash carries through untouched.
  task automatic test_mid_key_config();
    send_key_byte(8'd104, 1'b0, 1'b0);
    send_key_byte(8'd105, 1'b0, 1'b0);
    write_config(32'd131, 32'd10);
    send_key_byte(8'd106, 1'b1, 1'b0);
  endtask

  task automatic test_random_traffic(input int byte_total);
    send_random_keys(byte_total, -1);
  endtask

  // The receiver holds off for a long stretch while keys keep coming, so the
  // block fills and stalls its input; later the sender pauses until the
  // result channel has drained.
  task automatic test_backpressure(input int byte_total);
    receiver_hold_request = 1'b1;
    send_random_keys(byte_total, byte_total * 3 / 4);
  endtask

  // Receiver: runs of random length, each with its own readiness, from always
  // ready to fully stalled, plus the long hold-off on request.
  initial begin : result_receiver
    int run_left;
    int ready_pct;
    int hold_left;
    run_left = 0;
    ready_pct = 100;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (receiver_hold_request) begin
        receiver_hold_request = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(4, 60);
          case ($urandom_range(0, 3))
            0:       ready_pct = 100;
            1:       ready_pct = 75;
            2:       ready_pct = 35;
            default: ready_pct = 0;
          endcase
        end
        run_left--;
        result_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Every result transfer is matched against the oldest owed result.
  always @(posedge clk) begin : result_check
    bucket_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: full_hash %0d, bucket_index %0d", full_hash, bucket_index);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (full_hash !== want.full_hash) begin
          $error("full_hash mismatch: expected %0d, got %0d", want.full_hash, full_hash);
          mismatch_count++;
        end
        if (bucket_index !== want.bucket_index) begin
          $error("bucket_index mismatch: expected %0d, got %0d",
                 want.bucket_index, bucket_index);
          mismatch_count++;
        end
      end
    end
  end

  // Cycles with no transfer on any channel; a hang shows up as a long run.
  always @(posedge clk) begin
    if ((key_valid && key_ready) || (result_valid && result_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WatchdogLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : test_sequence
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_byte_extremes();
    test_base_and_count_extremes();
    test_mid_key_config();

    // Random phases, each under its own configuration.
    write_config(32'd2, 32'd1);
    test_random_traffic(120);
    write_config(32'd1000000008, 32'd65535);
    test_random_traffic(120);
    write_config($urandom, $urandom);
    test_backpressure(120);
    write_config(32'd31, 32'd0);
    test_random_traffic(120);
    write_config($urandom, 32'($urandom_range(1, 300)));
    test_random_traffic(130);
    write_config(32'd97, 32'd1024);
    test_random_traffic(120);

    // Drain, then give the block time to show any stray result.
    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rhbi_pkg.sv
rtl/core/rhbi_mulmod.sv
rtl/core/rhbi_datapath.sv
rtl/core/rhbi_ctrl.sv
rtl/core/rolling_hash_bucket_index.sv
sim/tb_top.sv
